### sv/text_console_character_writer_unit_assert.svh
// Assertion macros for the text console character writer.
// Taken in by the modules that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define TCCW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TCCW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCCW_ASSERT_IMP(label, ante, cons, msg)
`define TCCW_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### sv/tccw_pkg.sv
// Shared types, constants and helpers of the text console character writer.
// No dependencies; imported by every module of the block.
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int WIDE_W = ((ADDR_W > 11) ? ADDR_W : 11) + 1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [15:0]       cell_t;

    localparam row_t  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam col_t  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam addr_t CELL_LAST = ADDR_W'(CELL_COUNT - 1);

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] COLOR_RESET  = 8'd7;
    localparam cell_t      BLANK_RESET  = {COLOR_RESET, CH_SPACE};

    typedef enum logic [2:0] {
        REQ_PUT    = 3'd0,
        REQ_UP     = 3'd1,
        REQ_DOWN   = 3'd2,
        REQ_LEFT   = 3'd3,
        REQ_RIGHT  = 3'd4,
        REQ_DELETE = 3'd5,
        REQ_READ   = 3'd6,
        REQ_CLEAR  = 3'd7
    } req_kind_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  serial_byte;
        logic        serial_valid;
        logic [15:0] cell_data;
    } out_item_t;

    // One write port and one read port of the screen store.
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        cell_t wr_data;
        logic  rd_en;
        addr_t rd_addr;
    } ram_port_t;

    // What one request does to the cursor and to the cell under it.
    typedef struct packed {
        row_t       row_next;
        col_t       col_next;
        logic       wr_en;
        addr_t      wr_addr;
        logic [7:0] wr_char;
        logic       scroll;
    } cursor_plan_t;

    function automatic addr_t cell_addr(row_t r, col_t c);
        addr_t rr = ADDR_W'(r);
        return ADDR_W'(rr * ADDR_W'(COLUMNS)) + ADDR_W'(c);
    endfunction

    function automatic logic [10:0] pos_field(addr_t a);
        logic [WIDE_W-1:0] w = WIDE_W'(a);
        return w[10:0];
    endfunction

endpackage

### sv/tccw_screen_ram.sv
// Screen store of the text console: one cell per entry, synchronous read.
// Depends on tccw_pkg for the address and cell types.
module tccw_screen_ram
    import tccw_pkg::*;
(
    input  logic      clk,
    input  ram_port_t port,
    output cell_t     rd_data
);

    cell_t mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (port.wr_en)
        begin
            mem[port.wr_addr] <= port.wr_data;
        end
        if (port.rd_en)
        begin
            rd_data <= mem[port.rd_addr];
        end
    end

endmodule

### sv/tccw_cursor.sv
// Cursor arithmetic of the text console: next position, cell write and scroll request.
// Depends on tccw_pkg for the request codes and the plan struct.
module tccw_cursor
    import tccw_pkg::*;
(
    input  logic [2:0]   req_type,
    input  logic [7:0]   char_code,
    input  row_t         row,
    input  col_t         col,
    output cursor_plan_t plan
);

    row_t left_row;
    col_t left_col;
    row_t right_row;
    col_t right_col;

    // Stepping left or right wraps across a row end but stops at the screen corners.
    always_comb
    begin
        left_row  = row;
        left_col  = col;
        right_row = row;
        right_col = col;
        if (col != '0)
        begin
            left_col = col - 1'b1;
        end
        else if (row != '0)
        begin
            left_row = row - 1'b1;
            left_col = COL_LAST;
        end
        if (col != COL_LAST)
        begin
            right_col = col + 1'b1;
        end
        else if (row != ROW_LAST)
        begin
            right_row = row + 1'b1;
            right_col = '0;
        end
    end

    always_comb
    begin
        plan          = '0;
        plan.row_next = row;
        plan.col_next = col;
        plan.wr_addr  = cell_addr(row, col);
        plan.wr_char  = CH_SPACE;
        case (req_type)
            REQ_PUT:
            begin
                if (char_code == CH_NEWLINE)
                begin
                    plan.col_next = '0;
                    if (row == ROW_LAST)
                    begin
                        plan.scroll = 1'b1;
                    end
                    else
                    begin
                        plan.row_next = row + 1'b1;
                    end
                end
                else if (char_code == CH_BACKSPACE)
                begin
                    plan.row_next = left_row;
                    plan.col_next = left_col;
                    plan.wr_en    = 1'b1;
                    plan.wr_addr  = cell_addr(left_row, left_col);
                end
                else
                begin
                    plan.wr_en   = 1'b1;
                    plan.wr_char = char_code;
                    if (col == COL_LAST)
                    begin
                        plan.col_next = '0;
                        if (row == ROW_LAST)
                        begin
                            plan.scroll = 1'b1;
                        end
                        else
                        begin
                            plan.row_next = row + 1'b1;
                        end
                    end
                    else
                    begin
                        plan.col_next = col + 1'b1;
                    end
                end
            end
            REQ_UP:
            begin
                if (row != '0)
                begin
                    plan.row_next = row - 1'b1;
                end
            end
            REQ_DOWN:
            begin
                if (row != ROW_LAST)
                begin
                    plan.row_next = row + 1'b1;
                end
            end
            REQ_LEFT:
            begin
                plan.row_next = left_row;
                plan.col_next = left_col;
            end
            REQ_RIGHT:
            begin
                plan.row_next = right_row;
                plan.col_next = right_col;
            end
            REQ_DELETE:
            begin
                plan.wr_en    = 1'b1;
                plan.row_next = right_row;
                plan.col_next = right_col;
            end
            REQ_CLEAR:
            begin
                plan.row_next = '0;
                plan.col_next = '0;
            end
            default:
            begin
                plan.row_next = row;
                plan.col_next = col;
            end
        endcase
    end

endmodule

### sv/text_console_character_writer_unit.sv
// Top level of the text console character writer: handshakes, sequencer and output register.
// Depends on tccw_pkg, tccw_cursor, tccw_screen_ram and the assertion macro header.
//
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid / in_ready    in_data   (in_item_t: request, byte, cell index)
//  out      output     out_valid / out_ready  out_data  (out_item_t: cursor, echo, cell data)
//  cfg      input      cfg_valid / cfg_ready  cfg_data  (text colour, 8 bits)
//
// An item is taken in the idle state and carried out in the execute state once the output
// register is free; cursor moves, writes and deletes finish there, and a cell read passes
// through the read state for the store's registered read, unless the index lies off the
// screen. A scroll or a clear sweeps the whole store through its single write port, one
// cell a cycle, and a flush state writes the last cell before the next item is taken.
// After reset the same sweep blanks the store with in_ready low.
// A finished result waits in the output register; the next item is still taken meanwhile
// and is held until that register is free.
`include "text_console_character_writer_unit_assert.svh"

module text_console_character_writer_unit
    import tccw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    // Sequencer states. The sweep state walks the store for scroll, clear and the reset
    // pass; the flush state writes the last cell left in the write stage.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t       state_reg, state_next;
    in_item_t     item_reg, item_next;
    row_t         row_reg, row_next;
    col_t         col_reg, col_next;
    logic [7:0]   color_reg;
    addr_t        cnt_reg, cnt_next;
    logic         wr_active_reg, wr_active_next;
    addr_t        wr_addr_reg, wr_addr_next;
    logic         wr_copy_reg, wr_copy_next;
    logic         sweep_scroll_reg, sweep_scroll_next;
    logic         sweep_report_reg, sweep_report_next;
    cell_t        sweep_blank_reg, sweep_blank_next;
    logic         out_valid_reg;
    out_item_t    out_data_reg;

    logic         out_free;
    logic         out_load;
    out_item_t    out_new;
    logic         idx_in_range;
    cursor_plan_t plan;
    ram_port_t    ram;
    cell_t        ram_rd_data;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign idx_in_range = WIDE_W'(item_reg.cell_index) < WIDE_W'(CELL_COUNT);

    tccw_cursor u_cursor (
        .req_type  (item_reg.req_type),
        .char_code (item_reg.char_code),
        .row       (row_reg),
        .col       (col_reg),
        .plan      (plan)
    );

    tccw_screen_ram u_ram (
        .clk     (clk),
        .port    (ram),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        cnt_next          = cnt_reg;
        wr_active_next    = wr_active_reg;
        wr_addr_next      = wr_addr_reg;
        wr_copy_next      = wr_copy_reg;
        sweep_scroll_next = sweep_scroll_reg;
        sweep_report_next = sweep_report_reg;
        sweep_blank_next  = sweep_blank_reg;
        out_load          = 1'b0;
        ram               = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // Nothing starts until the output register can take this item's result,
                // so a long sweep always finds it empty at the end.
                if (out_free)
                begin
                    row_next     = plan.row_next;
                    col_next     = plan.col_next;
                    ram.wr_en    = plan.wr_en;
                    ram.wr_addr  = plan.wr_addr;
                    ram.wr_data  = {color_reg, plan.wr_char};
                    if (item_reg.req_type == REQ_READ)
                    begin
                        if (idx_in_range)
                        begin
                            ram.rd_en   = 1'b1;
                            ram.rd_addr = ADDR_W'(item_reg.cell_index);
                            state_next  = ST_READ;
                        end
                        else
                        begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else if (plan.scroll || item_reg.req_type == REQ_CLEAR)
                    begin
                        cnt_next          = '0;
                        wr_active_next    = 1'b0;
                        sweep_scroll_next = plan.scroll;
                        sweep_report_next = 1'b1;
                        sweep_blank_next  = {color_reg, CH_SPACE};
                        state_next        = ST_SWEEP;
                    end
                    else
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                out_load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                // Read one row ahead; each cell is written from the write stage registers. Reads always
                // run at least a row below the writes, so a read never meets a fresh write.
                ram.rd_en   = sweep_scroll_reg && (cnt_reg < ADDR_W'(MOVE_COUNT));
                ram.rd_addr = cnt_reg + ADDR_W'(COLUMNS);
                ram.wr_en   = wr_active_reg;
                ram.wr_addr = wr_addr_reg;
                ram.wr_data = wr_copy_reg ? ram_rd_data : sweep_blank_reg;
                wr_active_next = 1'b1;
                wr_addr_next   = cnt_reg;
                wr_copy_next   = ram.rd_en;
                if (cnt_reg == CELL_LAST)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                ram.wr_en      = wr_active_reg;
                ram.wr_addr    = wr_addr_reg;
                ram.wr_data    = wr_copy_reg ? ram_rd_data : sweep_blank_reg;
                wr_active_next = 1'b0;
                out_load       = sweep_report_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result fields: the cursor as it stands after the request, the echo on put_char and
    // the cell read, which only a read request fills.
    always_comb
    begin
        out_new              = '0;
        out_new.cursor_pos   = pos_field(cell_addr(row_next, col_next));
        out_new.serial_valid = (item_reg.req_type == REQ_PUT);
        out_new.serial_byte  = out_new.serial_valid ? item_reg.char_code : 8'd0;
        out_new.cell_data    = (state_reg == ST_READ) ? ram_rd_data : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Reset starts the blanking pass over the whole store.
            state_reg        <= ST_SWEEP;
            row_reg          <= '0;
            col_reg          <= '0;
            color_reg        <= COLOR_RESET;
            cnt_reg          <= '0;
            wr_active_reg    <= 1'b0;
            wr_copy_reg      <= 1'b0;
            sweep_scroll_reg <= 1'b0;
            sweep_report_reg <= 1'b0;
            sweep_blank_reg  <= BLANK_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            cnt_reg          <= cnt_next;
            wr_active_reg    <= wr_active_next;
            wr_copy_reg      <= wr_copy_next;
            sweep_scroll_reg <= sweep_scroll_next;
            sweep_report_reg <= sweep_report_next;
            sweep_blank_reg  <= sweep_blank_next;
            if (cfg_valid && cfg_ready)
            begin
                color_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        wr_addr_reg <= wr_addr_next;
        if (out_load)
        begin
            out_data_reg <= out_new;
        end
    end

    `TCCW_ASSERT_IMP(a_no_result_overwrite, out_load, out_free,
        "result loaded while the previous one was still waiting")
    `TCCW_ASSERT_IMP(a_sweep_ports_apart, ram.rd_en && ram.wr_en, ram.rd_addr != ram.wr_addr,
        "scroll read and write hit the same cell")
    `TCCW_ASSERT_IMP(a_cursor_in_screen, 1'b1, row_reg <= ROW_LAST && col_reg <= COL_LAST,
        "cursor left the screen")
    `TCCW_ASSERT_NXT(a_sweep_ends_home, state_reg == ST_FLUSH && sweep_report_reg,
        col_reg == '0 && (row_reg == '0 || row_reg == ROW_LAST),
        "cursor not at a row start after a scroll or clear")

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_character_writer_unit: directed edge cases,
// colour changes, a long result stall and random request traffic, each result predicted.
// Depends on tccw_pkg and the RTL of the text console character writer.

module testbench;
    import tccw_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    // Cycles in a row with no item moving on any channel before the run is declared hung.
    // The slowest legal stretch is a scroll or clear sweep of the whole store, or the
    // long result stall below; this limit is several times either.
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASES       = 5;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    // Our own copy of the console: screen cells, cursor and the current attribute byte.
    cell_t      screen_copy [CELL_COUNT];
    int         cur_row;
    int         cur_col;
    logic [7:0] attr_byte;

    // Results still owed by the block, oldest first.
    out_item_t  status_backlog [$];

    int fault_count = 0;
    int stall_count = 0;

    // Idling switches for the request side and the result side, and a request for one
    // long stall of the result side.
    bit tx_gaps      = 1'b1;
    bit rx_gaps      = 1'b1;
    bit hold_pending = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    text_console_character_writer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------------------
    // Console prediction
    // ------------------------------------------------------------------------------------

    // Blank cells are a space in the current colour.
    function automatic void blank_from(int first);
        for (int i = first; i < CELL_COUNT; i++)
        begin
            screen_copy[i] = {attr_byte, CH_SPACE};
        end
    endfunction

    // The cursor is always on the screen, so no bounds check is needed here.
    function automatic void put_cell(logic [7:0] ch);
        screen_copy[cur_row * COLUMNS + cur_col] = {attr_byte, ch};
    endfunction

    // Left with wrap to the end of the row above; stays put at the top-left corner.
    function automatic void step_back();
        if (cur_col > 0)
        begin
            cur_col--;
        end
        else if (cur_row > 0)
        begin
            cur_row--;
            cur_col = COLUMNS - 1;
        end
    endfunction

    // Right with wrap to the start of the row below; stays put at the bottom-right corner.
    function automatic void step_fwd();
        if (cur_col < COLUMNS - 1)
        begin
            cur_col++;
        end
        else if (cur_row < ROWS - 1)
        begin
            cur_row++;
            cur_col = 0;
        end
    endfunction

    // Applies one request to the console copy and returns the result it must produce.
    function automatic out_item_t console_update(in_item_t req);
        out_item_t res;
        res = '0;
        case (req_kind_t'(req.req_type))
            REQ_PUT:
            begin
                if (req.char_code == CH_NEWLINE)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else if (req.char_code == CH_BACKSPACE)
                begin
                    step_back();
                    put_cell(CH_SPACE);
                end
                else
                begin
                    put_cell(req.char_code);
                    cur_col++;
                    if (cur_col == COLUMNS)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                // Falling off the bottom scrolls everything up one row and blanks the last.
                if (cur_row == ROWS)
                begin
                    for (int i = 0; i < MOVE_COUNT; i++)
                    begin
                        screen_copy[i] = screen_copy[i + COLUMNS];
                    end
                    blank_from(MOVE_COUNT);
                    cur_row = ROWS - 1;
                end
                res.serial_byte  = req.char_code;
                res.serial_valid = 1'b1;
            end
            REQ_UP:
            begin
                if (cur_row > 0)
                    cur_row--;
            end
            REQ_DOWN:
            begin
                if (cur_row < ROWS - 1)
                    cur_row++;
            end
            REQ_LEFT:   step_back();
            REQ_RIGHT:  step_fwd();
            REQ_DELETE:
            begin
                put_cell(CH_SPACE);
                step_fwd();
            end
            REQ_READ:
            begin
                // Indexes past the screen read as zero.
                if (req.cell_index < CELL_COUNT)
                    res.cell_data = screen_copy[req.cell_index];
            end
            REQ_CLEAR:
            begin
                blank_from(0);
                cur_row = 0;
                cur_col = 0;
            end
        endcase
        res.cursor_pos = 11'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the block's own registers
    // and our nonblocking drives have moved, so the order of processes does not matter.
    // The result side is checked before a new request is predicted, so a result can
    // never be matched against the item accepted in the same cycle.
    // ------------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            attr_byte = COLOR_RESET;
            cur_row   = 0;
            cur_col   = 0;
            blank_from(0);
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (status_backlog.size() == 0)
                begin
                    $error("result item arrived with none awaited: %h", out_data);
                    fault_count++;
                end
                else
                begin
                    want = status_backlog.pop_front();
                    if (out_data.cursor_pos !== want.cursor_pos)
                    begin
                        $error("cursor_pos: expected %0d, got %0d",
                               want.cursor_pos, out_data.cursor_pos);
                        fault_count++;
                    end
                    if (out_data.serial_byte !== want.serial_byte)
                    begin
                        $error("serial_byte: expected %h, got %h",
                               want.serial_byte, out_data.serial_byte);
                        fault_count++;
                    end
                    if (out_data.serial_valid !== want.serial_valid)
                    begin
                        $error("serial_valid: expected %b, got %b",
                               want.serial_valid, out_data.serial_valid);
                        fault_count++;
                    end
                    if (out_data.cell_data !== want.cell_data)
                    begin
                        $error("cell_data: expected %h, got %h",
                               want.cell_data, out_data.cell_data);
                        fault_count++;
                    end
                end
            end
            // Colour writes only happen while the block is idle, never beside a request.
            if (cfg_valid && cfg_ready)
                attr_byte = cfg_data;
            if (in_valid && in_ready)
                status_backlog.push_back(console_update(in_data));
        end
    end

    // Watchdog: a long run of cycles with nothing accepted anywhere means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stall_count = 0;
        end
        else
        begin
            stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Result side: for every item it draws a random wait (or none at all when its gaps are
    // switched off), then raises out_ready until an item goes through. When a long stall
    // has been asked for, it is added to the next wait, so the block fills up behind its
    // output register and has to push back on the request side.
    // ------------------------------------------------------------------------------------
    initial
    begin : result_sink
        int wait_cycles;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            wait_cycles = rx_gaps ? $urandom_range(0, 11) : 0;
            if (hold_pending)
            begin
                wait_cycles += HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------------------

    // Offers one request item after a random gap and returns at the edge that takes it.
    // in_valid is left high so back-to-back items carry no bubble.
    task automatic send_request(input req_kind_t kind, input logic [7:0] ch,
                                input logic [10:0] idx);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= '{kind, ch, idx};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // The fields a request does not use are filled with noise all the same.
    task automatic move(input req_kind_t kind);
        send_request(kind, 8'($urandom), 11'($urandom));
    endtask

    task automatic type_byte(input logic [7:0] ch);
        send_request(REQ_PUT, ch, 11'($urandom));
    endtask

    task automatic read_at(input logic [10:0] idx);
        send_request(REQ_READ, 8'($urandom), idx);
    endtask

    // Stops offering requests and waits until every owed result is in. Every request
    // gives a result, so an empty backlog means the block is idle; a further wait then lets
    // its output stage settle. The first wait lets the monitor record an item accepted
    // at the edge this task was called on.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_backlog.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_colour(input logic [7:0] value);
        settle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Reset contents, then the top-left corner: moves that must not go anywhere,
    // backspace there, character extremes, delete, and wrapping between rows.
    task automatic test_top_left_edges();
        read_at(11'd0);
        read_at(11'(CELL_LAST));
        move(REQ_UP);
        move(REQ_LEFT);
        type_byte(CH_BACKSPACE);
        type_byte(8'h41);
        type_byte(8'h00);
        type_byte(8'hFF);
        read_at(11'd1);
        read_at(11'd2);
        move(REQ_LEFT);
        move(REQ_DELETE);
        type_byte(CH_BACKSPACE);
        read_at(11'd2);
        type_byte(CH_NEWLINE);
        move(REQ_LEFT);
        move(REQ_RIGHT);
        move(REQ_UP);
        move(REQ_CLEAR);
        read_at(11'd0);
    endtask

    // Walks down to the bottom row and works the bottom edge: down there, a newline
    // and a byte at the last column that scroll, wrapping at the last column, right and delete
    // at the bottom-right corner, and reads past the end of the screen.
    task automatic test_bottom_edges_and_scroll();
        move(REQ_CLEAR);
        repeat (ROWS) move(REQ_DOWN);
        type_byte(8'h51);
        type_byte(CH_NEWLINE);
        read_at(11'((ROWS - 2) * COLUMNS));
        move(REQ_LEFT);
        move(REQ_RIGHT);
        move(REQ_LEFT);
        move(REQ_DOWN);
        move(REQ_RIGHT);
        move(REQ_DELETE);
        type_byte(8'h5A);
        read_at(11'((ROWS - 2) * COLUMNS + COLUMNS - 1));
        read_at(11'((ROWS - 1) * COLUMNS));
        read_at(11'(CELL_COUNT));
        read_at(11'h7FF);
    endtask

    // Blank and written cells must take the colour in force at the time.
    task automatic test_colour_extremes();
        logic [7:0] shades [2];
        shades[0] = 8'hFF;
        shades[1] = 8'h00;
        for (int k = 0; k < 2; k++)
        begin
            write_colour(shades[k]);
            move(REQ_CLEAR);
            read_at(11'd0);
            type_byte(8'h7E);
            read_at(11'd0);
            type_byte(CH_BACKSPACE);
            read_at(11'd0);
        end
    endtask

    // The result side stalls for a long stretch while requests keep coming with no gaps.
    task automatic test_backpressure();
        tx_gaps      = 1'b0;
        hold_pending = 1'b1;
        for (int k = 0; k < 16; k++)
        begin
            if (k % 2 == 0)
                type_byte(8'($urandom_range(8'h21, 8'h7E)));
            else
                read_at(11'($urandom_range(0, CELL_COUNT - 1)));
        end
        tx_gaps = 1'b1;
        settle();
    endtask

    // Random traffic: put requests of random bytes with some control characters, cursor moves,
    // deletes and reads, and the odd clear. Clears and bottom-row newlines each sweep the
    // whole store, so they are kept rare. Half the reads look just behind the cursor where
    // text has been written; the rest range over the whole 11-bit index.
    task automatic test_random_traffic(input int count);
        int         roll;
        int         base;
        logic [7:0] ch;
        logic [10:0] idx;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            ch   = 8'($urandom);
            idx  = 11'($urandom);
            if (roll < 45)
            begin
                case ($urandom_range(0, 19))
                    0, 1: ch = CH_NEWLINE;
                    2:    ch = CH_BACKSPACE;
                    default: ;
                endcase
                send_request(REQ_PUT, ch, idx);
            end
            else if (roll < 52)
                send_request(REQ_UP, ch, idx);
            else if (roll < 62)
                send_request(REQ_DOWN, ch, idx);
            else if (roll < 68)
                send_request(REQ_LEFT, ch, idx);
            else if (roll < 76)
                send_request(REQ_RIGHT, ch, idx);
            else if (roll < 82)
                send_request(REQ_DELETE, ch, idx);
            else if (roll < 98)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    base = cur_row * COLUMNS + cur_col - int'($urandom_range(0, 2 * COLUMNS));
                    idx  = 11'((base < 0) ? 0 : base);
                end
                send_request(REQ_READ, ch, idx);
            end
            else
                send_request(REQ_CLEAR, ch, idx);
        end
    endtask

    // The random part in phases, each with its own colour; the first and last idle on both
    // sides, the others drop gaps on one side or, in one of them, on both.
    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_colour(8'h00);
                1:       write_colour(8'hFF);
                default: write_colour(8'($urandom));
            endcase
            tx_gaps = (p != 1) && (p != 3);
            rx_gaps = (p != 2) && (p != 3);
            test_random_traffic(RANDOM_ITEMS / PHASES);
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // Reset is held from the start and released once; the block then blanks its store
    // with in_ready low, which the first request simply waits out.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_top_left_edges();
        test_bottom_edges_and_scroll();
        test_colour_extremes();
        test_backpressure();
        test_random_phases();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/tccw_pkg.sv
sv/tccw_screen_ram.sv
sv/tccw_cursor.sv
sv/text_console_character_writer_unit.sv
verif/testbench.sv
